// ===== rtl/srq_pkg.sv =====
// ----------------------------------------------------------------------------
// srq_pkg: shared types and constants of the sorted ready queue
// Record, request and response layouts, codes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package srq_pkg;

   // default sizes
   localparam int DefQueueDepth = 16;
   localparam int DefKeyBits    = 16;
   localparam int DefPidBits    = 16;

   localparam int CountOutBits  = 5;

   // request action codes
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_REMOVE = 1'b1;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [15:0] proc_id;
      logic [15:0] arrival_time;
      logic [15:0] run_length;
      logic [7:0]  resource_tag;
   } rec_type;

   typedef struct packed {
      logic        action;
      logic [15:0] proc_id;
      logic [15:0] arrival_time;
      logic [15:0] run_length;
      logic [7:0]  resource_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic                    head_valid;
      logic [15:0]             out_proc_id;
      logic [15:0]             out_arrival;
      logic [15:0]             out_run_length;
      logic [7:0]              out_resource;
      logic [CountOutBits-1:0] entry_count;
   } rsp_type;

   // per-cycle control broadcast to every cell
   typedef struct packed {
      logic load_new;
      logic pop;
      logic by_duration;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/srq_cell.sv =====
// ----------------------------------------------------------------------------
// srq_cell: one slot of the sorted ready queue
// Holds one record, compares it with the incoming record and shifts with its
// neighbors on insert and remove.
// ----------------------------------------------------------------------------
`default_nettype none

module srq_cell #(
   parameter int KEY_BITS = srq_pkg::DefKeyBits,
   parameter int PID_BITS = srq_pkg::DefPidBits
) (
   input  wire                    clock,
   input  srq_pkg::cell_ctl_type  ctl,
   input  wire                    occupied,
   input  srq_pkg::rec_type       new_rec,
   input  srq_pkg::rec_type       left_rec,
   input  srq_pkg::rec_type       right_rec,
   input  wire                    shift_in,
   output logic                   shift_out,
   output srq_pkg::rec_type       rec_out
);
   import srq_pkg::*;

   rec_type             rec_ff;
   rec_type             rec_in;
   logic [KEY_BITS-1:0] key_new;
   logic [KEY_BITS-1:0] key_old;
   logic [PID_BITS-1:0] pid_new;
   logic [PID_BITS-1:0] pid_old;
   logic                goes_before;
   logic                hit;

   always_comb begin
      if (ctl.by_duration) begin
         key_new = KEY_BITS'(32'(new_rec.run_length));
         key_old = KEY_BITS'(32'(rec_ff.run_length));
      end else begin
         key_new = KEY_BITS'(32'(new_rec.arrival_time));
         key_old = KEY_BITS'(32'(rec_ff.arrival_time));
      end
      pid_new = PID_BITS'(32'(new_rec.proc_id));
      pid_old = PID_BITS'(32'(rec_ff.proc_id));
      goes_before = (key_new < key_old) || ((key_new == key_old) && (pid_new < pid_old));
      // an empty slot always accepts: append at the tail
      hit = !occupied || goes_before;
   end

   assign shift_out = shift_in || hit;

   always_comb begin
      rec_in = rec_ff;
      if (ctl.load_new) begin
         if (shift_in) begin
            rec_in = left_rec;
         end else if (hit) begin
            rec_in = new_rec;
         end
      end else if (ctl.pop) begin
         rec_in = right_rec;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec_out = rec_ff;

endmodule

`default_nettype wire

// ===== rtl/sorted_ready_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_ready_queue: bounded ready queue of process records
// Keeps records ordered by arrival time or duration, pid breaking ties, in a
// row of slots that shift on insert and remove.
//
//   channel  direction  handshake                 payload
//   req      in         start & !busy             req_data (req_type)
//   rsp      out        rsp_valid, one cycle      rsp_data (rsp_type)
//   csr      in         csr_valid & csr_ready     csr_data (order_by_duration)
//
// One transaction per cycle: every slot compares with the new record in
// parallel and the whole row shifts together, so busy stays low.
// The response comes on the cycle after the request, held for one cycle.
// Synchronous reset empties the queue and selects ordering by arrival time;
// no clearing pass is needed. The receiver cannot stall the response.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_ready_queue #(
   parameter int QUEUE_DEPTH = srq_pkg::DefQueueDepth,
   parameter int KEY_BITS    = srq_pkg::DefKeyBits,
   parameter int PID_BITS    = srq_pkg::DefPidBits
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  srq_pkg::req_type  req_data,
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire               csr_data,
   output logic              rsp_valid,
   output srq_pkg::rsp_type  rsp_data
);
   import srq_pkg::*;

   localparam int CntBits = $clog2(QUEUE_DEPTH + 1);

   logic [CntBits-1:0]   count_ff;
   logic [CntBits-1:0]   count_in;
   logic                 by_dur_ff;
   logic                 by_dur_in;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;

   logic                 accept;
   logic                 is_full;
   logic                 is_empty;
   cell_ctl_type         ctl;
   rec_type              new_rec;
   rec_type              cell_rec [QUEUE_DEPTH];
   logic [QUEUE_DEPTH:0] shift_chain;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   assign is_full  = (count_ff == CntBits'(QUEUE_DEPTH));
   assign is_empty = (count_ff == '0);

   assign new_rec.proc_id      = req_data.proc_id;
   assign new_rec.arrival_time = req_data.arrival_time;
   assign new_rec.run_length   = req_data.run_length;
   assign new_rec.resource_tag = req_data.resource_tag;

   always_comb begin
      ctl.load_new    = accept && (req_data.action == ACT_INSERT) && !is_full;
      ctl.pop         = accept && (req_data.action == ACT_REMOVE) && !is_empty;
      ctl.by_duration = by_dur_ff;
   end

   assign shift_chain[0] = 1'b0;

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      rec_type left_rec;
      rec_type right_rec;

      if (g == 0) begin : g_first
         assign left_rec = new_rec;
      end else begin : g_mid
         assign left_rec = cell_rec[g-1];
      end

      if (g == QUEUE_DEPTH - 1) begin : g_last
         assign right_rec = cell_rec[g];
      end else begin : g_inner
         assign right_rec = cell_rec[g+1];
      end

      srq_cell #(
         .KEY_BITS (KEY_BITS),
         .PID_BITS (PID_BITS)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .occupied  (CntBits'(g) < count_ff),
         .new_rec   (new_rec),
         .left_rec  (left_rec),
         .right_rec (right_rec),
         .shift_in  (shift_chain[g]),
         .shift_out (shift_chain[g+1]),
         .rec_out   (cell_rec[g])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.load_new) begin
         count_in = count_ff + CntBits'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CntBits'(1);
      end

      by_dur_in = by_dur_ff;
      if (csr_valid && csr_ready) begin
         by_dur_in = csr_data;
      end

      rsp_in = '0;
      if (req_data.action == ACT_INSERT) begin
         rsp_in.status = is_full ? ST_FULL : ST_OK;
      end else if (is_empty) begin
         rsp_in.status = ST_EMPTY;
      end else begin
         rsp_in.status         = ST_OK;
         rsp_in.head_valid     = 1'b1;
         rsp_in.out_proc_id    = cell_rec[0].proc_id;
         rsp_in.out_arrival    = cell_rec[0].arrival_time;
         rsp_in.out_run_length = cell_rec[0].run_length;
         rsp_in.out_resource   = cell_rec[0].resource_tag;
      end
      rsp_in.entry_count = CountOutBits'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         by_dur_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         by_dur_ff    <= by_dur_in;
         rsp_valid_ff <= accept;
      end
   end

   // hold the response payload between transactions
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
